// File: hdl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
package owbm_pkg;

   // Most bits one write or read transaction may move
   localparam int unsigned MAX_BITS = 8;

   // Request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_RESET = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_MANY = 2'd1;
   localparam logic [1:0] ST_FAULT    = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   // Control register indexes
   localparam logic [2:0] CSR_RESET_LOW  = 3'd0;
   localparam logic [2:0] CSR_SLOT       = 3'd1;
   localparam logic [2:0] CSR_ONE_LOW    = 3'd2;
   localparam logic [2:0] CSR_ZERO_LOW   = 3'd3;
   localparam logic [2:0] CSR_SAMPLE     = 3'd4;
   localparam logic [2:0] CSR_IDLE_WIN   = 3'd5;
   localparam logic [2:0] CSR_FAULT_TIME = 3'd6;

   localparam int unsigned CSR_DATA_W = 20;

   // Register values after reset
   localparam logic [9:0]  RST_RESET_LOW  = 10'd480;
   localparam logic [7:0]  RST_SLOT       = 8'd75;
   localparam logic [7:0]  RST_ONE_LOW    = 8'd2;
   localparam logic [7:0]  RST_ZERO_LOW   = 8'd65;
   localparam logic [7:0]  RST_SAMPLE     = 8'd13;
   localparam logic [9:0]  RST_IDLE_WIN   = 10'd540;
   localparam logic [19:0] RST_FAULT_TIME = 20'd100000;

   // Bus timing settings handed from the register file to the engine
   typedef struct packed {
      logic [9:0]  reset_low_ticks;
      logic [7:0]  slot_ticks;
      logic [7:0]  one_low_ticks;
      logic [7:0]  zero_low_ticks;
      logic [7:0]  sample_ticks;
      logic [9:0]  idle_window_ticks;
      logic [19:0] fault_timeout_ticks;
   } cfg_type;

   // Engine phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_RLOW  = 5'b00010,
      PH_RWAIT = 5'b00100,
      PH_WRITE = 5'b01000,
      PH_READ  = 5'b10000
   } phase_type;

endpackage

// File: hdl/one_wire_bus_master_unit.sv
// One-wire bus master: per-tick bus engine with a registered response.
//
//   channel  | ports            | direction | transaction
//   req      | req_valid/ready  | in        | one 1 us tick: action, bit count, byte, line level
//   rsp      | rsp_valid/ready  | out       | one per req: drive, busy, done, presence, data, status
//   csr      | csr_we           | in        | timing register write, no wait
//
// Each req transaction is worked in the cycle it is accepted and its response
// lands in the output register on that edge: one transaction per cycle while the output register is not stalled.
// The output register is the only stall point: req_ready drops only while a
// response is held and rsp_ready is low. Synchronous active-high reset clears
// the engine to idle and loads the default timing; no clearing pass.
module one_wire_bus_master_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [3:0]                         req_bit_count,
   input  logic [7:0]                         req_write_byte,
   input  logic                               req_line_level,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_drive_low,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic                               rsp_presence,
   output logic [7:0]                         rsp_rx_byte,
   output logic [1:0]                         rsp_status,
   // control registers
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import owbm_pkg::*;

   cfg_type cfg;

   // engine state
   phase_type   phase_ff,     phase_in;
   logic [19:0] tick_ff,      tick_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [3:0]  bits_total_ff, bits_total_in;
   logic [7:0]  shift_ff,     shift_in;
   logic        seen_high_ff, seen_high_in;
   logic        presence_ff,  presence_in;
   logic [7:0]  read_hold_ff, read_hold_in;

   // response register
   logic        rsp_valid_ff;
   logic        drive_ff,  drive_in;
   logic        busy_ff,   busy_in;
   logic        done_ff,   done_in;
   logic [1:0]  status_ff, status_in;

   logic        accept;
   logic        reject;
   logic [1:0]  st;
   logic [20:0] next_tick;
   logic [7:0]  low_ticks;
   logic [3:0]  bit_inc;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // One tick of bus work: start decode, then the phase step
   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_index_in  = bit_index_ff;
      bits_total_in = bits_total_ff;
      shift_in      = shift_ff;
      seen_high_in  = seen_high_ff;
      presence_in   = presence_ff;
      read_hold_in  = read_hold_ff;
      drive_in      = 1'b0;
      done_in       = 1'b0;
      reject        = 1'b0;
      st            = ST_OK;
      low_ticks     = 8'd0;
      bit_inc       = bit_index_ff + 4'd1;

      // command decode, only when idle
      if (phase_ff == PH_IDLE) begin
         if (req_action == ACT_RESET) begin
            presence_in  = 1'b0;
            seen_high_in = 1'b0;
            tick_in      = 20'd0;
            phase_in     = PH_RLOW;
         end else if (req_action == ACT_WRITE || req_action == ACT_READ) begin
            if (req_bit_count > 4'(MAX_BITS)) begin
               done_in = 1'b1;
               st      = ST_TOO_MANY;
            end else if (req_bit_count == 4'd0) begin
               done_in = 1'b1;
               if (req_action == ACT_READ) begin
                  read_hold_in = 8'd0;
               end
            end else begin
               bits_total_in = req_bit_count;
               bit_index_in  = 4'd0;
               shift_in      = (req_action == ACT_WRITE) ? req_write_byte : 8'd0;
               tick_in       = 20'd0;
               seen_high_in  = 1'b0;
               phase_in      = (req_action == ACT_WRITE) ? PH_WRITE : PH_READ;
            end
         end
      end else if (req_action != ACT_TICK) begin
         reject = 1'b1;
      end

      next_tick = {1'b0, tick_in} + 21'd1;
      bit_inc   = bit_index_in + 4'd1;

      // phase step for this tick
      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_RLOW: begin
            drive_in = 1'b1;
            if (next_tick >= 21'(cfg.reset_low_ticks)) begin
               phase_in     = PH_RWAIT;
               tick_in      = 20'd0;
               seen_high_in = 1'b0;
            end else begin
               tick_in = next_tick[19:0];
            end
         end
         PH_RWAIT: begin
            // high then low again inside the window means presence
            if (req_line_level) begin
               seen_high_in = 1'b1;
            end else if (seen_high_in) begin
               presence_in = 1'b1;
            end
            if (seen_high_in && next_tick >= 21'(cfg.idle_window_ticks)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else if (!seen_high_in &&
                         next_tick >= 21'(cfg.fault_timeout_ticks)) begin
               phase_in    = PH_IDLE;
               presence_in = 1'b0;
               done_in     = 1'b1;
               st          = ST_FAULT;
            end else begin
               tick_in = next_tick[19:0];
            end
         end
         PH_WRITE: begin
            low_ticks = shift_in[0] ? cfg.one_low_ticks : cfg.zero_low_ticks;
            drive_in  = (tick_in < 20'(low_ticks));
            if (next_tick >= 21'(cfg.slot_ticks)) begin
               shift_in     = {1'b0, shift_in[7:1]};
               bit_index_in = bit_inc;
               tick_in      = 20'd0;
               if (bit_inc >= bits_total_in) begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            end else begin
               tick_in = next_tick[19:0];
            end
         end
         PH_READ: begin
            low_ticks = cfg.one_low_ticks;
            drive_in  = (tick_in < 20'(low_ticks));
            if (!drive_in && req_line_level && tick_in < 20'(cfg.sample_ticks)) begin
               seen_high_in = 1'b1;
            end
            if (next_tick >= 21'(cfg.slot_ticks)) begin
               // shift in from the top, right-align at the end
               shift_in     = {seen_high_in, shift_in[7:1]};
               seen_high_in = 1'b0;
               bit_index_in = bit_inc;
               tick_in      = 20'd0;
               if (bit_inc >= bits_total_in) begin
                  phase_in     = PH_IDLE;
                  done_in      = 1'b1;
                  read_hold_in = shift_in >> (3'(4'd8 - bits_total_in));
               end
            end else begin
               tick_in = next_tick[19:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      busy_in   = (phase_in != PH_IDLE);
      status_in = done_in ? st : (reject ? ST_BUSY : ST_OK);
   end

   // engine state, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= 20'd0;
         bit_index_ff  <= 4'd0;
         bits_total_ff <= 4'd0;
         shift_ff      <= 8'd0;
         seen_high_ff  <= 1'b0;
         presence_ff   <= 1'b0;
         read_hold_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_index_ff  <= bit_index_in;
         bits_total_ff <= bits_total_in;
         shift_ff      <= shift_in;
         seen_high_ff  <= seen_high_in;
         presence_ff   <= presence_in;
         read_hold_ff  <= read_hold_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff  <= drive_in;
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_presence  = presence_ff;
   assign rsp_rx_byte   = read_hold_ff;
   assign rsp_status    = status_ff;

endmodule

// File: hdl/owbm_csr.sv
// Timing register file for the one-wire bus master.
module owbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output owbm_pkg::cfg_type                  cfg
);
   import owbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed field; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_LOW:  cfg_in.reset_low_ticks     = csr_wdata[9:0];
            CSR_SLOT:       cfg_in.slot_ticks          = csr_wdata[7:0];
            CSR_ONE_LOW:    cfg_in.one_low_ticks       = csr_wdata[7:0];
            CSR_ZERO_LOW:   cfg_in.zero_low_ticks      = csr_wdata[7:0];
            CSR_SAMPLE:     cfg_in.sample_ticks        = csr_wdata[7:0];
            CSR_IDLE_WIN:   cfg_in.idle_window_ticks   = csr_wdata[9:0];
            CSR_FAULT_TIME: cfg_in.fault_timeout_ticks = csr_wdata[19:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RST_RESET_LOW;
         cfg_ff.slot_ticks          <= RST_SLOT;
         cfg_ff.one_low_ticks       <= RST_ONE_LOW;
         cfg_ff.zero_low_ticks      <= RST_ZERO_LOW;
         cfg_ff.sample_ticks        <= RST_SAMPLE;
         cfg_ff.idle_window_ticks   <= RST_IDLE_WIN;
         cfg_ff.fault_timeout_ticks <= RST_FAULT_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
